// ===== hdl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg
// Types and constants shared by the keyed scan result table modules.
// ----------------------------------------------------------------------------
package kst_pkg;

	localparam int CAPACITY   = 64;
	localparam int BEACON_MAX = 512;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int LEN_W      = 10;
	localparam int CQ_DEPTH   = 2;
	localparam int OQ_DEPTH   = 4;
	localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_CLEAR  = 2'd1;
	localparam logic [1:0] MODE_SNAP   = 2'd2;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_CLEAR,
		OP_SNAP,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SNAP,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic [47:0]       bssid;
		logic [15:0]       freq_mhz;
		logic signed [7:0] rssi_dbm;
		logic [31:0]       seen_tick;
		logic [LEN_W-1:0]  beacon_length;
	} entry_t;

	typedef struct packed {
		op_t              op;
		entry_t           entry;
		logic [CNT_W-1:0] max_count;
	} cmd_t;

	typedef struct packed {
		logic             status;
		logic             entry_valid;
		logic [IDX_W-1:0] entry_index;
		entry_t           entry;
		logic [CNT_W-1:0] returned_count;
		logic             last;
	} result_t;

endpackage

// ===== hdl/kst_ram.sv =====
// ----------------------------------------------------------------------------
// kst_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/kst_front.sv =====
// ----------------------------------------------------------------------------
// kst_front
// Accepts input transactions, decodes the mode, clamps the beacon length
// and holds the commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module kst_front import kst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        mode,
	input  logic [47:0]       bssid,
	input  logic [15:0]       freq_mhz,
	input  logic signed [7:0] rssi_dbm,
	input  logic [15:0]       beacon_length,
	input  logic [31:0]       current_tick,
	input  logic [CNT_W-1:0]  max_count,
	output logic              cq_valid,
	output cmd_t              cq_cmd,
	input  logic              cq_pop
);

	localparam int PTR_W = $clog2(CQ_DEPTH);

	cmd_t                         cmd_in;
	cmd_t                         mem_q [CQ_DEPTH];
	logic [PTR_W-1:0]             wr_ptr_q;
	logic [PTR_W-1:0]             rd_ptr_q;
	logic [$clog2(CQ_DEPTH+1)-1:0] occ_q;
	logic                         do_push;
	logic                         do_pop;

	always_comb begin
		case (mode)
			MODE_INSERT: cmd_in.op = OP_INSERT;
			MODE_CLEAR:  cmd_in.op = OP_CLEAR;
			MODE_SNAP:   cmd_in.op = OP_SNAP;
			default:     cmd_in.op = OP_NOP;
		endcase
		cmd_in.entry.bssid     = bssid;
		cmd_in.entry.freq_mhz  = freq_mhz;
		cmd_in.entry.rssi_dbm  = rssi_dbm;
		cmd_in.entry.seen_tick = current_tick;
		if (beacon_length > 16'(BEACON_MAX)) begin
			cmd_in.entry.beacon_length = LEN_W'(BEACON_MAX);
		end else begin
			cmd_in.entry.beacon_length = beacon_length[LEN_W-1:0];
		end
		cmd_in.max_count = max_count;
	end

	assign full     = (occ_q == ($clog2(CQ_DEPTH+1))'(CQ_DEPTH));
	assign cq_valid = (occ_q != '0);
	assign cq_cmd   = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = cq_pop && cq_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				occ_q <= occ_q + 1'b1;
			end else if (do_pop && !do_push) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/kst_outq.sv =====
// ----------------------------------------------------------------------------
// kst_outq
// Result queue between the back end and the consumer.
// ----------------------------------------------------------------------------
module kst_outq import kst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  result_t             push_data,
	input  logic                pop,
	output logic                empty,
	output result_t             head,
	output logic [OQ_CNT_W-1:0] occ
);

	localparam int PTR_W = $clog2(OQ_DEPTH);

	result_t          mem_q [OQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] occ_q;
	logic             do_pop;

	assign empty  = (occ_q == '0);
	assign head   = mem_q[rd_ptr_q];
	assign occ    = occ_q;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				occ_q <= occ_q + 1'b1;
			end else if (do_pop && !push) begin
				occ_q <= occ_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/kst_back.sv =====
// ----------------------------------------------------------------------------
// kst_back
// Sequencer that carries out commands: linear key search with update or
// append, clear, and snapshot readout from the entry RAM.
// ----------------------------------------------------------------------------
module kst_back import kst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CNT_W-1:0]    cfg_wr_data,
	input  logic                cq_valid,
	input  cmd_t                cq_cmd,
	output logic                cq_pop,
	input  logic [OQ_CNT_W-1:0] oq_occ,
	output logic                oq_push,
	output result_t             oq_data
);

	state_t           state_q;
	state_t           state_d;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] max_entries_q;
	logic [CNT_W-1:0] idx_q;
	logic             rd_vld_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] snap_n_q;
	result_t          reply_q;

	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] snap_n;
	logic             hit;
	logic             rd_issue;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic             do_full;
	logic             do_append;
	logic             oq_room;
	entry_t           ram_rdata;
	result_t          snap_res;
	result_t          reply_init;

	kst_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cmd_q.entry),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign limit  = (max_entries_q > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : max_entries_q;
	assign snap_n = (count_q < cq_cmd.max_count) ? count_q : cq_cmd.max_count;
	assign hit    = rd_vld_q && (ram_rdata.bssid == cmd_q.entry.bssid);
	// one slot kept for the read already in flight
	assign oq_room = ({1'b0, oq_occ} + (OQ_CNT_W+1)'(rd_vld_q)) < (OQ_CNT_W+1)'(OQ_DEPTH);

	always_comb begin
		reply_init      = '0;
		reply_init.last = 1'b1;
	end

	always_comb begin
		snap_res                = '0;
		snap_res.entry_valid    = 1'b1;
		snap_res.entry_index    = rd_idx_q;
		snap_res.entry          = ram_rdata;
		snap_res.returned_count = snap_n_q;
		snap_res.last           = ({1'b0, rd_idx_q} == (snap_n_q - 1'b1));
	end

	always_comb begin
		state_d   = state_q;
		cq_pop    = 1'b0;
		rd_issue  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = rd_idx_q;
		do_full   = 1'b0;
		do_append = 1'b0;
		oq_push   = 1'b0;
		oq_data   = snap_res;
		case (state_q)
			ST_IDLE: begin
				if (cq_valid) begin
					cq_pop = 1'b1;
					case (cq_cmd.op)
						OP_INSERT: state_d = ST_SEARCH;
						OP_SNAP:   state_d = (snap_n == '0) ? ST_REPLY : ST_SNAP;
						default:   state_d = ST_REPLY;
					endcase
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					ram_we  = 1'b1;
					state_d = ST_REPLY;
				end else if (idx_q < count_q) begin
					rd_issue = 1'b1;
				end else if (!rd_vld_q) begin
					state_d = ST_REPLY;
					if (count_q >= limit) begin
						do_full = 1'b1;
					end else begin
						do_append = 1'b1;
						ram_we    = 1'b1;
						ram_waddr = count_q[IDX_W-1:0];
					end
				end
			end
			ST_SNAP: begin
				oq_push = rd_vld_q;
				if (idx_q < snap_n_q) begin
					rd_issue = oq_room;
				end else if (!rd_vld_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_REPLY: begin
				oq_data = reply_q;
				if (oq_occ < OQ_CNT_W'(OQ_DEPTH)) begin
					oq_push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			max_entries_q <= CNT_W'(CAPACITY);
			idx_q         <= '0;
			rd_vld_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_entries_q <= cfg_wr_data;
			end
			if (cq_pop) begin
				idx_q    <= '0;
				rd_vld_q <= 1'b0;
				if (cq_cmd.op == OP_CLEAR) begin
					count_q <= '0;
				end
			end else begin
				rd_vld_q <= rd_issue;
				if (rd_issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (do_append) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rd_idx_q <= idx_q[IDX_W-1:0];
		end
		if (cq_pop) begin
			cmd_q    <= cq_cmd;
			snap_n_q <= snap_n;
			reply_q  <= reply_init;
		end else if (state_q == ST_SEARCH) begin
			if (hit) begin
				reply_q.entry_index <= rd_idx_q;
			end else if (do_full) begin
				reply_q.status <= 1'b1;
			end else if (do_append) begin
				reply_q.entry_index <= count_q[IDX_W-1:0];
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> (oq_occ < OQ_CNT_W'(OQ_DEPTH)))
		else $error("result queue pushed while full");

	a_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_SEARCH))
		else $error("entry write outside search");

	a_snap_data_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SNAP && rd_vld_q) |-> oq_push)
		else $error("snapshot read data dropped");

endmodule

// ===== hdl/keyed_scan_result_table_core.sv =====
// throughput: one item at a time in the back end, set by the single-read-port key
// search and by snapshot readout of one entry per cycle while the result queue
// has room; a two-deep command queue takes further items meanwhile. reset clears the
// count, sets the limit to 64, and leaves table contents undefined (no clearing pass)
// ----------------------------------------------------------------------------
// keyed_scan_result_table_core
// Table of access-point records keyed by station address, with insert or
// update, clear and snapshot readout.
// ----------------------------------------------------------------------------
module keyed_scan_result_table_core import kst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [6:0]        cfg_wr_data,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        mode,
	input  logic [47:0]       bssid,
	input  logic [15:0]       freq_mhz,
	input  logic signed [7:0] rssi_dbm,
	input  logic [15:0]       beacon_length,
	input  logic [31:0]       current_tick,
	input  logic [6:0]        max_count,
	output logic              empty,
	input  logic              pop,
	output logic              status,
	output logic              entry_valid,
	output logic [5:0]        entry_index,
	output logic [47:0]       out_bssid,
	output logic [15:0]       out_freq_mhz,
	output logic signed [7:0] out_rssi_dbm,
	output logic [31:0]       out_seen_tick,
	output logic [9:0]        out_beacon_length,
	output logic [6:0]        returned_count,
	output logic              last
);

	logic                cq_valid;
	cmd_t                cq_cmd;
	logic                cq_pop;
	logic [OQ_CNT_W-1:0] oq_occ;
	logic                oq_push;
	result_t             oq_data;
	result_t             head;

	kst_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.bssid        (bssid),
		.freq_mhz     (freq_mhz),
		.rssi_dbm     (rssi_dbm),
		.beacon_length(beacon_length),
		.current_tick (current_tick),
		.max_count    (max_count),
		.cq_valid     (cq_valid),
		.cq_cmd       (cq_cmd),
		.cq_pop       (cq_pop)
	);

	kst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cq_valid   (cq_valid),
		.cq_cmd     (cq_cmd),
		.cq_pop     (cq_pop),
		.oq_occ     (oq_occ),
		.oq_push    (oq_push),
		.oq_data    (oq_data)
	);

	kst_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (oq_push),
		.push_data(oq_data),
		.pop      (pop),
		.empty    (empty),
		.head     (head),
		.occ      (oq_occ)
	);

	assign status            = head.status;
	assign entry_valid       = head.entry_valid;
	assign entry_index       = head.entry_index;
	assign out_bssid         = head.entry.bssid;
	assign out_freq_mhz      = head.entry.freq_mhz;
	assign out_rssi_dbm      = head.entry.rssi_dbm;
	assign out_seen_tick     = head.entry.seen_tick;
	assign out_beacon_length = head.entry.beacon_length;
	assign returned_count    = head.returned_count;
	assign last              = head.last;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyed scan result table. A directed table
// covers limits, key extremes, beacon clamping, clear, undefined mode and
// snapshots. Random phases then run under several entry limits with a mix of
// new and repeated keys. Every result transaction is checked field by field
// against an in-bench copy of the table or a row's given status and index.
// ----------------------------------------------------------------------------
module tb_top;
	import kst_pkg::*;

	localparam logic [1:0] MODE_UNDEF = 2'd3;
	localparam int PHASE_ITEMS = 30;
	localparam int HOLD_CYCLES = 300;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [6:0]        cfg_wr_data;
	logic              push;
	logic              full;
	logic [1:0]        mode;
	logic [47:0]       bssid;
	logic [15:0]       freq_mhz;
	logic signed [7:0] rssi_dbm;
	logic [15:0]       beacon_length;
	logic [31:0]       current_tick;
	logic [6:0]        max_count;
	logic              empty;
	logic              pop;
	logic              status;
	logic              entry_valid;
	logic [5:0]        entry_index;
	logic [47:0]       out_bssid;
	logic [15:0]       out_freq_mhz;
	logic signed [7:0] out_rssi_dbm;
	logic [31:0]       out_seen_tick;
	logic [9:0]        out_beacon_length;
	logic [6:0]        returned_count;
	logic              last;

	keyed_scan_result_table_core uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.push              (push),
		.full              (full),
		.mode              (mode),
		.bssid             (bssid),
		.freq_mhz          (freq_mhz),
		.rssi_dbm          (rssi_dbm),
		.beacon_length     (beacon_length),
		.current_tick      (current_tick),
		.max_count         (max_count),
		.empty             (empty),
		.pop               (pop),
		.status            (status),
		.entry_valid       (entry_valid),
		.entry_index       (entry_index),
		.out_bssid         (out_bssid),
		.out_freq_mhz      (out_freq_mhz),
		.out_rssi_dbm      (out_rssi_dbm),
		.out_seen_tick     (out_seen_tick),
		.out_beacon_length (out_beacon_length),
		.returned_count    (returned_count),
		.last              (last)
	);

	typedef struct {
		bit          is_cfg;
		logic [6:0]  cfg_val;
		logic [1:0]  md;
		logic [47:0] key;
		logic [15:0] fq;
		logic [7:0]  lvl;
		logic [15:0] blen;
		logic [31:0] tk;
		logic [6:0]  mc;
		bit          typed;
		logic        t_status;
		logic [5:0]  t_index;
	} stim_row_t;

	// bench copy of the table
	logic [47:0]       key_tab   [CAPACITY];
	logic [15:0]       freq_tab  [CAPACITY];
	logic signed [7:0] level_tab [CAPACITY];
	logic [31:0]       tick_tab  [CAPACITY];
	logic [LEN_W-1:0]  len_tab   [CAPACITY];
	int                tab_count;
	logic [6:0]        lim_reg;

	result_t     scan_replies [$];
	result_t     pending_results [$];
	stim_row_t   dir_tab [$];
	logic [47:0] known_keys [$];

	int errors;
	int n_items;
	int n_inserts;
	int n_results;
	int n_full;
	int n_entries;
	bit tx_idle;
	bit rx_idle;
	bit hold_req;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#(10_000_000);
		$display("TB_ERROR");
		$finish;
	end

	function automatic void table_update(input logic [1:0] md, input logic [47:0] key,
			input logic [15:0] fq, input logic [7:0] lvl, input logic [15:0] blen,
			input logic [31:0] tk, input logic [6:0] mc);
		result_t r;
		int slot;
		int cap;
		int n;
		scan_replies.delete();
		r = '0;
		r.last = 1'b1;
		case (md)
			MODE_INSERT: begin
				cap = (lim_reg > 7'(CAPACITY)) ? CAPACITY : int'(lim_reg);
				slot = -1;
				for (int i = 0; i < tab_count; i++)
					if (slot < 0 && key_tab[i] == key) slot = i;
				if (slot < 0 && tab_count >= cap) begin
					r.status = 1'b1;
				end else begin
					if (slot < 0) begin
						slot = tab_count;
						tab_count++;
						key_tab[slot] = key;
					end
					freq_tab[slot]  = fq;
					level_tab[slot] = lvl;
					tick_tab[slot]  = tk;
					len_tab[slot]   = (blen > 16'(BEACON_MAX)) ? LEN_W'(BEACON_MAX) : LEN_W'(blen);
					r.entry_index   = IDX_W'(slot);
				end
				scan_replies.push_back(r);
			end
			MODE_SNAP: begin
				n = (tab_count < int'(mc)) ? tab_count : int'(mc);
				if (n > CAPACITY) n = CAPACITY;
				if (n == 0) scan_replies.push_back(r);
				for (int k = 0; k < n; k++) begin
					r = '0;
					r.entry_valid          = 1'b1;
					r.entry_index          = IDX_W'(k);
					r.entry.bssid          = key_tab[k];
					r.entry.freq_mhz       = freq_tab[k];
					r.entry.rssi_dbm       = level_tab[k];
					r.entry.seen_tick      = tick_tab[k];
					r.entry.beacon_length  = len_tab[k];
					r.returned_count       = CNT_W'(n);
					r.last                 = (k == n - 1);
					scan_replies.push_back(r);
				end
			end
			MODE_CLEAR: begin
				tab_count = 0;
				scan_replies.push_back(r);
			end
			default: begin
				// undefined mode leaves the table alone
				scan_replies.push_back(r);
			end
		endcase
	endfunction

	function automatic stim_row_t op_row(input logic [1:0] md, input logic [47:0] key,
			input logic [15:0] fq, input logic [7:0] lvl, input logic [15:0] blen,
			input logic [31:0] tk, input logic [6:0] mc, input bit typed,
			input logic ts, input logic [5:0] ti);
		stim_row_t s;
		s = '{is_cfg: 1'b0, cfg_val: '0, md: md, key: key, fq: fq, lvl: lvl, blen: blen,
			tk: tk, mc: mc, typed: typed, t_status: ts, t_index: ti};
		return s;
	endfunction

	function automatic stim_row_t cfg_row(input logic [6:0] v);
		stim_row_t s;
		s = op_row(MODE_UNDEF, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0);
		s.is_cfg  = 1'b1;
		s.cfg_val = v;
		return s;
	endfunction

	function automatic void field_check(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// entered and left at a falling edge
	task automatic send_item(input logic [1:0] md, input logic [47:0] key,
			input logic [15:0] fq, input logic [7:0] lvl, input logic [15:0] blen,
			input logic [31:0] tk, input logic [6:0] mc, input bit typed,
			input logic ts, input logic [5:0] ti);
		int gap;
		result_t r;
		gap = tx_idle ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push          <= 1'b1;
		mode          <= md;
		bssid         <= key;
		freq_mhz      <= fq;
		rssi_dbm      <= lvl;
		beacon_length <= blen;
		current_tick  <= tk;
		max_count     <= mc;
		do @(posedge clk); while (full);
		table_update(md, key, fq, lvl, blen, tk, mc);
		if (typed) begin
			r = '0;
			r.status      = ts;
			r.entry_index = ti;
			r.last        = 1'b1;
			pending_results.push_back(r);
		end else begin
			foreach (scan_replies[i]) pending_results.push_back(scan_replies[i]);
		end
		n_items++;
		if (md == MODE_INSERT) n_inserts++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic settle_and_config(input logic [6:0] v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		lim_reg = v;
	endtask

	// result side: random pop gaps, one long hold-off on request
	initial begin
		result_t want;
		int gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = rx_idle ? $urandom_range(0, 4) : 0;
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected (index 0x%0h)", entry_index);
				errors++;
			end else begin
				want = pending_results.pop_front();
				n_results++;
				if (want.status) n_full++;
				if (want.entry_valid) n_entries++;
				field_check("status", 64'(want.status), 64'(status));
				field_check("entry_valid", 64'(want.entry_valid), 64'(entry_valid));
				field_check("entry_index", 64'(want.entry_index), 64'(entry_index));
				field_check("out_bssid", 64'(want.entry.bssid), 64'(out_bssid));
				field_check("out_freq_mhz", 64'(want.entry.freq_mhz), 64'(out_freq_mhz));
				field_check("out_rssi_dbm", 64'(want.entry.rssi_dbm), 64'(out_rssi_dbm));
				field_check("out_seen_tick", 64'(want.entry.seen_tick), 64'(out_seen_tick));
				field_check("out_beacon_length", 64'(want.entry.beacon_length),
					64'(out_beacon_length));
				field_check("returned_count", 64'(want.returned_count), 64'(returned_count));
				field_check("last", 64'(want.last), 64'(last));
			end
			@(negedge clk);
		end
	end

	initial begin
		int lim_tab [8]   = '{64, 127, 3, 0, 40, 1, 64, 127};
		int new_pct [8]   = '{80, 90, 50, 70, 60, 50, 30, 90};
		int clr_pct [8]   = '{2, 0, 5, 5, 5, 5, 3, 0};
		int pick;
		logic [63:0] w;
		logic [1:0]  md;
		logic [47:0] key;
		logic [6:0]  mc;
		logic [15:0] blen;

		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		push          = 1'b0;
		mode          = MODE_INSERT;
		bssid         = '0;
		freq_mhz      = '0;
		rssi_dbm      = '0;
		beacon_length = '0;
		current_tick  = '0;
		max_count     = '0;
		tab_count     = 0;
		lim_reg       = 7'd64;
		errors        = 0;
		tx_idle       = 1'b1;
		rx_idle       = 1'b1;
		hold_req      = 1'b0;

		// directed part: empty table, key extremes, clamp edges, limits
		dir_tab.push_back(op_row(MODE_SNAP, '0, '0, '0, '0, '0, 7'd0, 1, 0, 6'd0));
		dir_tab.push_back(op_row(MODE_INSERT, 48'h0, 16'h0, 8'h80, 16'd0, 32'h0, '0,
			1, 0, 6'd0));
		dir_tab.push_back(op_row(MODE_INSERT, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'h7F,
			16'hFFFF, 32'hFFFF_FFFF, 7'h7F, 1, 0, 6'd1));
		dir_tab.push_back(op_row(MODE_INSERT, 48'h0, 16'd2412, 8'hD8, 16'd512, 32'd100,
			'0, 1, 0, 6'd0));
		dir_tab.push_back(op_row(MODE_INSERT, 48'h0123_4567_89AB, 16'd5180, 8'hC0,
			16'd513, 32'd200, '0, 1, 0, 6'd2));
		dir_tab.push_back(op_row(MODE_SNAP, '0, '0, '0, '0, '0, 7'd127, 0, 0, 6'd0));
		dir_tab.push_back(op_row(MODE_UNDEF, 48'h5555_AAAA_5555, 16'h1234, 8'h11,
			16'd40, 32'd7, 7'd5, 1, 0, 6'd0));
		dir_tab.push_back(op_row(MODE_SNAP, '0, '0, '0, '0, '0, 7'd2, 0, 0, 6'd0));
		dir_tab.push_back(op_row(MODE_CLEAR, '0, '0, '0, '0, '0, '0, 1, 0, 6'd0));
		dir_tab.push_back(op_row(MODE_SNAP, '0, '0, '0, '0, '0, 7'd64, 1, 0, 6'd0));
		dir_tab.push_back(cfg_row(7'd0));
		dir_tab.push_back(op_row(MODE_INSERT, 48'hA, 16'd2437, 8'hB0, 16'd80, 32'd300,
			'0, 1, 1, 6'd0));
		dir_tab.push_back(op_row(MODE_SNAP, '0, '0, '0, '0, '0, 7'd1, 1, 0, 6'd0));
		dir_tab.push_back(cfg_row(7'd2));
		dir_tab.push_back(op_row(MODE_INSERT, 48'hA, 16'd2437, 8'hB0, 16'd80, 32'd301,
			'0, 1, 0, 6'd0));
		dir_tab.push_back(op_row(MODE_INSERT, 48'hB, 16'd2462, 8'hA0, 16'd90, 32'd302,
			'0, 1, 0, 6'd1));
		dir_tab.push_back(op_row(MODE_INSERT, 48'hC, 16'd5745, 8'h90, 16'd99, 32'd303,
			'0, 1, 1, 6'd0));
		dir_tab.push_back(op_row(MODE_INSERT, 48'hA, 16'd5200, 8'hE0, 16'd700, 32'd304,
			'0, 1, 0, 6'd0));
		// limit now below the count: updates still land, new keys bounce
		dir_tab.push_back(cfg_row(7'd1));
		dir_tab.push_back(op_row(MODE_INSERT, 48'hB, 16'd2412, 8'hF0, 16'd1, 32'd305,
			'0, 1, 0, 6'd1));
		dir_tab.push_back(op_row(MODE_INSERT, 48'hD, 16'd2412, 8'hF0, 16'd1, 32'd306,
			'0, 1, 1, 6'd0));
		dir_tab.push_back(op_row(MODE_SNAP, '0, '0, '0, '0, '0, 7'd127, 0, 0, 6'd0));
		dir_tab.push_back(cfg_row(7'd127));
		dir_tab.push_back(op_row(MODE_INSERT, 48'hD, 16'd2412, 8'hF0, 16'd1, 32'd307,
			'0, 1, 0, 6'd2));
		dir_tab.push_back(op_row(MODE_SNAP, '0, '0, '0, '0, '0, 7'd3, 0, 0, 6'd0));
		dir_tab.push_back(op_row(MODE_CLEAR, '0, '0, '0, '0, '0, '0, 1, 0, 6'd0));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				settle_and_config(dir_tab[i].cfg_val);
			else
				send_item(dir_tab[i].md, dir_tab[i].key, dir_tab[i].fq, dir_tab[i].lvl,
					dir_tab[i].blen, dir_tab[i].tk, dir_tab[i].mc, dir_tab[i].typed,
					dir_tab[i].t_status, dir_tab[i].t_index);
		end

		// random phases, one entry limit each; keys partly drawn from a pool of earlier keys
		for (int ph = 0; ph < 8; ph++) begin
			settle_and_config(7'(lim_tab[ph]));
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			if (ph == 2) begin
				// keep offering while the result side stalls so the input backs up
				tx_idle  = 1'b0;
				hold_req = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < clr_pct[ph])
					md = MODE_CLEAR;
				else if (pick < clr_pct[ph] + 3)
					md = MODE_UNDEF;
				else if (pick < clr_pct[ph] + 15)
					md = MODE_SNAP;
				else
					md = MODE_INSERT;
				if (known_keys.size() != 0 && $urandom_range(0, 99) >= new_pct[ph]) begin
					key = known_keys[$urandom_range(0, known_keys.size() - 1)];
				end else begin
					w = {$urandom, $urandom};
					key = w[47:0];
					if (known_keys.size() < 96)
						known_keys.push_back(key);
					else
						known_keys[$urandom_range(0, 95)] = key;
				end
				mc   = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
					: 7'($urandom_range(0, 8));
				blen = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(400, 700))
					: 16'($urandom);
				send_item(md, key, 16'($urandom), 8'($urandom), blen, $urandom, mc,
					1'b0, 1'b0, '0);
			end
		end

		drain_results();
		repeat (80) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d result transactions never arrived", pending_results.size());
			errors++;
		end
		$display("run covered %0d items (%0d inserts) over limits 0, 1, 2, 3, 40, 64, 127",
			n_items, n_inserts);
		$display("checked %0d results: %0d table-full replies, %0d snapshot entries",
			n_results, n_full, n_entries);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
